### rtl/smpq_pkg.sv
// ----------------------------------------------------------------------------
// smpq_pkg: shared types for the stable minimum priority queue
// Payload structs, operation and status codes, and the entry held by a cell.
// ----------------------------------------------------------------------------
package smpq_pkg;

    localparam int ELEM_W  = 32;
    localparam int PRIO_W  = 16;
    localparam int COUNT_W = 5;

    typedef enum logic
    {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        STATUS_OK         = 2'd0,
        STATUS_DEQ_EMPTY  = 2'd1,
        STATUS_ENQ_FULL   = 2'd2
    } status_t;

    typedef struct packed
    {
        op_t                operation;
        logic [ELEM_W-1:0]  new_elem;
        logic [PRIO_W-1:0]  new_priority;
    } in_item_t;

    typedef struct packed
    {
        logic [ELEM_W-1:0]  front_elem;
        logic [PRIO_W-1:0]  front_priority;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        status_t            status;
    } out_item_t;

    typedef struct packed
    {
        logic [ELEM_W-1:0] elem;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // broadcast from the top level to every cell
    typedef struct packed
    {
        logic   enq;
        logic   deq;
        entry_t fresh;
    } cell_ctrl_t;

    // what one cell shows its neighbors
    typedef struct packed
    {
        logic   valid;
        logic   shift;
        entry_t entry;
    } cell_link_t;

endpackage

### rtl/smpq_cell.sv
// ----------------------------------------------------------------------------
// smpq_cell: one slot of the sorted chain
// Holds one entry; on enqueue shifts right or takes the new entry, on dequeue
// takes the entry of its right neighbor.
// ----------------------------------------------------------------------------
module smpq_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  smpq_pkg::cell_ctrl_t ctrl,
    input  smpq_pkg::cell_link_t left,
    input  smpq_pkg::cell_link_t right,
    output smpq_pkg::cell_link_t self
);
    import smpq_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    entry_t entry_reg;
    entry_t entry_next;
    logic   shift;

    // new entry goes before this one only when strictly higher number here
    assign shift = valid_reg && (entry_reg.prio > ctrl.fresh.prio);

    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.enq)
        begin
            if (shift)
            begin
                entry_next = left.shift ? left.entry : ctrl.fresh;
            end
            else if (!valid_reg && left.valid)
            begin
                valid_next = 1'b1;
                entry_next = left.shift ? left.entry : ctrl.fresh;
            end
        end
        else if (ctrl.deq)
        begin
            valid_next = right.valid;
            if (right.valid)
            begin
                entry_next = right.entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign self.valid = valid_reg;
    assign self.shift = shift;
    assign self.entry = entry_reg;

endmodule

### rtl/stable_min_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_min_priority_queue: sorted cell-chain priority queue
// Keeps entries in ascending priority order, equal priorities in arrival
// order; each transaction enqueues or dequeues and reports the new front.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  input    | in_valid / in_stall    | in_data  (operation, elem, priority)
//  output   | out_valid / out_stall  | out_data (front, count, empty, status)
//
//  one transaction a cycle while in_stall is low: every cell compares and
//  updates in parallel, and the result is registered in the same cycle the
//  chain updates; in_stall is high only while a result is held and out_stall
//  is high
//  reset empties the chain at once (valid bits only, no clearing pass)
// ----------------------------------------------------------------------------
module stable_min_priority_queue
#(
    parameter int DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  smpq_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output smpq_pkg::out_item_t  out_data
);
    import smpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    cell_link_t      links [DEPTH];
    cell_link_t      lefts [DEPTH];
    cell_link_t      rights[DEPTH];
    cell_ctrl_t      ctrl;

    logic            accept;
    logic            full;
    logic            empty;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic            out_valid_reg;
    out_item_t       out_reg;
    out_item_t       out_next;
    entry_t          front_next;
    logic            front_valid_next;
    entry_t          fresh;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign empty    = !links[0].valid;
    assign full     = links[DEPTH-1].valid;

    assign fresh.elem = in_data.new_elem;
    assign fresh.prio = in_data.new_priority;

    assign ctrl.enq   = accept && (in_data.operation == OP_ENQUEUE) && !full;
    assign ctrl.deq   = accept && (in_data.operation == OP_DEQUEUE) && !empty;
    assign ctrl.fresh = fresh;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign lefts[g] = '{valid: 1'b1, shift: 1'b0, entry: '0};
            end
            else
            begin : g_mid
                assign lefts[g] = links[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_tail
                assign rights[g] = '{valid: 1'b0, shift: 1'b0, entry: '0};
            end
            else
            begin : g_body
                assign rights[g] = links[g+1];
            end
            smpq_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (lefts[g]),
                .right (rights[g]),
                .self  (links[g])
            );
        end
    endgenerate

    // front after the update, mirrors what cell zero will load
    always_comb
    begin
        front_valid_next = links[0].valid;
        front_next       = links[0].entry;
        count_next       = count_reg;
        if (ctrl.enq)
        begin
            front_valid_next = 1'b1;
            count_next       = count_reg + CNT_W'(1);
            if (!links[0].valid || links[0].shift)
            begin
                front_next = fresh;
            end
        end
        else if (ctrl.deq)
        begin
            front_valid_next = links[1].valid;
            front_next       = links[1].entry;
            count_next       = count_reg - CNT_W'(1);
        end

        out_next.front_elem     = front_valid_next ? front_next.elem : '0;
        out_next.front_priority = front_valid_next ? front_next.prio : '0;
        out_next.entry_count    = COUNT_W'(count_next);
        out_next.is_empty       = !front_valid_next;
        if (in_data.operation == OP_ENQUEUE)
        begin
            out_next.status = full ? STATUS_ENQ_FULL : STATUS_OK;
        end
        else
        begin
            out_next.status = empty ? STATUS_DEQ_EMPTY : STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the stable minimum priority queue
// Drives enqueue and dequeue transactions in random bursts, with the receiver
// stalling on its own pattern and once holding off long enough to back up the
// input. A sorted-list predictor gives the expected front, count, empty flag
// and status for every transaction without a typed-in expectation; results are checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 64;
    localparam int DRAIN_CYCLES = 10;

    typedef struct
    {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    // travels alongside in_data so a typed-in expectation stays with its row
    logic      typed_row;
    out_item_t typed_result;

    entry_t    held_entries[$];
    out_item_t expected_results[$];
    stim_row_t directed_rows[$];

    int error_count     = 0;
    int accepted_inputs = 0;
    int idle_cycles     = 0;
    int burst_left      = 0;

    stable_min_priority_queue #(.DEPTH(QUEUE_DEPTH)) u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic out_item_t result_of(input logic [ELEM_W-1:0] elem,
                                            input logic [PRIO_W-1:0] prio,
                                            input logic [COUNT_W-1:0] count,
                                            input logic empty,
                                            input status_t status);
        out_item_t res;
        res.front_elem     = elem;
        res.front_priority = prio;
        res.entry_count    = count;
        res.is_empty       = empty;
        res.status         = status;
        return res;
    endfunction

    // applies one transaction to the sorted list and returns the new front
    function automatic out_item_t apply_to_list(input in_item_t item);
        out_item_t res;
        entry_t    fresh;
        int        pos;
        res.status = STATUS_OK;
        if (item.operation == OP_ENQUEUE)
        begin
            if (held_entries.size() >= QUEUE_DEPTH)
                res.status = STATUS_ENQ_FULL;
            else
            begin
                fresh.elem = item.new_elem;
                fresh.prio = item.new_priority;
                pos = 0;
                // equal priorities stay in arrival order
                while (pos < held_entries.size() && held_entries[pos].prio <= fresh.prio)
                    pos++;
                held_entries.insert(pos, fresh);
            end
        end
        else
        begin
            if (held_entries.size() == 0)
                res.status = STATUS_DEQ_EMPTY;
            else
                void'(held_entries.pop_front());
        end
        if (held_entries.size() > 0)
        begin
            res.front_elem     = held_entries[0].elem;
            res.front_priority = held_entries[0].prio;
            res.is_empty       = 1'b0;
        end
        else
        begin
            res.front_elem     = '0;
            res.front_priority = '0;
            res.is_empty       = 1'b1;
        end
        res.entry_count = COUNT_W'(held_entries.size());
        return res;
    endfunction

    function automatic void add_row(input op_t op, input logic [ELEM_W-1:0] elem,
                                    input logic [PRIO_W-1:0] prio, input logic typed,
                                    input out_item_t res);
        stim_row_t row;
        row.item.operation    = op;
        row.item.new_elem     = elem;
        row.item.new_priority = prio;
        row.typed             = typed;
        row.result            = res;
        directed_rows.push_back(row);
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic offer(input in_item_t item, input logic typed, input out_item_t res);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid     <= 1'b1;
        in_data      <= item;
        typed_row    <= typed;
        typed_result <= res;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial
    begin : stimulus
        in_item_t item;
        int       seg_left;
        int       enq_pct;
        int       prio_mode;
        in_valid     <= 1'b0;
        in_data      <= '0;
        typed_row    <= 1'b0;
        typed_result <= '0;

        add_row(OP_DEQUEUE, '0, '0, 1'b1, result_of('0, '0, 5'd0, 1'b1, STATUS_DEQ_EMPTY));
        add_row(OP_ENQUEUE, '1, '1, 1'b1, result_of('1, '1, 5'd1, 1'b0, STATUS_OK));
        add_row(OP_ENQUEUE, '0, '0, 1'b1, result_of('0, '0, 5'd2, 1'b0, STATUS_OK));
        // ties at both ends of the priority range go behind the earlier entry
        add_row(OP_ENQUEUE, 32'hA5A5_A5A5, '1, 1'b0, '0);
        add_row(OP_ENQUEUE, 32'h5A5A_5A5A, '0, 1'b0, '0);
        repeat (3) add_row(OP_DEQUEUE, '0, '0, 1'b0, '0);
        for (int k = 1; k < QUEUE_DEPTH; k++)
            add_row(OP_ENQUEUE, ELEM_W'(k), '1, 1'b0, '0);
        // full: dropped even though it would become the front
        add_row(OP_ENQUEUE, 32'h1234_5678, '0, 1'b1,
                result_of(32'hA5A5_A5A5, '1, 5'd16, 1'b0, STATUS_ENQ_FULL));
        add_row(OP_DEQUEUE, '1, '1, 1'b0, '0);

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);

        seg_left  = 0;
        enq_pct   = 50;
        prio_mode = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // segments lean toward filling or draining so full and empty recur
            if (seg_left == 0)
            begin
                seg_left  = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0:       enq_pct = 25;
                    1:       enq_pct = 50;
                    default: enq_pct = 80;
                endcase
                prio_mode = $urandom_range(0, 2);
            end
            seg_left--;
            item.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            item.new_elem  = $urandom;
            case (prio_mode)
                0:       item.new_priority = PRIO_W'($urandom_range(0, 65535));
                1:       item.new_priority = PRIO_W'($urandom_range(0, 3));
                default: item.new_priority = $urandom_range(0, 1) ? '1 : '0;
            endcase
            offer(item, 1'b0, '0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // receiver: stall pattern in segments, plus one long hold-off
    initial
    begin : receiver
        int   seg_len;
        int   stall_pct;
        logic long_hold_done;
        out_stall <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!long_hold_done && accepted_inputs > 400)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1'b1;
            end
            seg_len = $urandom_range(10, 80);
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                default: stall_pct = 60;
            endcase
            repeat (seg_len)
            begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : scoreboard
        out_item_t predicted;
        out_item_t exp_res;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = apply_to_list(in_data);
                expected_results.push_back(typed_row ? typed_result : predicted);
                accepted_inputs++;
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction: %h", out_data);
                    error_count++;
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (out_data.front_elem !== exp_res.front_elem)
                    begin
                        $error("front_elem: expected %h, got %h",
                               exp_res.front_elem, out_data.front_elem);
                        error_count++;
                    end
                    if (out_data.front_priority !== exp_res.front_priority)
                    begin
                        $error("front_priority: expected %h, got %h",
                               exp_res.front_priority, out_data.front_priority);
                        error_count++;
                    end
                    if (out_data.entry_count !== exp_res.entry_count)
                    begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_res.entry_count, out_data.entry_count);
                        error_count++;
                    end
                    if (out_data.is_empty !== exp_res.is_empty)
                    begin
                        $error("is_empty: expected %b, got %b",
                               exp_res.is_empty, out_data.is_empty);
                        error_count++;
                    end
                    if (out_data.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               exp_res.status, out_data.status);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

endmodule

### sim.f
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue.sv
dv/tb_top.sv
